>>> sv/assert_macros.svh
// Assertion macros shared by the tile header directory check RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define THDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition implies another condition in the same cycle.
`define THDC_ASSERT_IMP(lbl, ante, cons, msg) \
    `THDC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> sv/thdc_pkg.sv
// Package for the tile header directory check: types, layout constants, CRC step.
// No dependencies; imported by every module of the block.
`default_nettype none

package thdc_pkg;

    localparam int POS_W    = 9;
    localparam int HDR_W    = 128;
    localparam int ENTRY_W  = 168;
    localparam int TDATA_W  = 312;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    localparam logic [POS_W-1:0] P_VERSION  = 9'd4;
    localparam logic [POS_W-1:0] P_ZOOM     = 9'd6;
    localparam logic [POS_W-1:0] P_HDR_END  = 9'd23;
    localparam logic [POS_W-1:0] P_CRC_LO   = 9'd31;
    localparam logic [POS_W-1:0] P_CRC_END  = 9'd35;
    localparam logic [POS_W-1:0] P_COUNT    = 9'd35;
    localparam logic [POS_W-1:0] P_BODY     = 9'd36;
    localparam logic [4:0]       K_LAST     = 5'd20;

    localparam logic [31:0]     CRC_POLY  = 32'hEDB88320;
    localparam logic [3:0][7:0] MAGIC_TAG = {8'h31, 8'h42, 8'h49, 8'h54};

    localparam logic [7:0] CFG_IDX_VERSION     = 8'd0;
    localparam logic [7:0] CFG_IDX_LAYER_LIMIT = 8'd1;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_ENTRY   = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_TOO_MANY    = 3'd3,
        ST_CRC_BAD     = 3'd4
    } status_t;

    typedef enum logic {
        BK_FIRST  = 1'b0,
        BK_SECOND = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [15:0] expected_version;
        logic [3:0]  layer_limit;
    } cfg_t;

    typedef struct packed {
        kind_t                first_kind;
        status_t              first_status;
        logic                 has_verdict;
        status_t              verdict_status;
        logic [ENTRY_W-1:0]   data;
    } evt_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
        logic               empty;
    } q_stat_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'b0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/thdc_front.sv
// Front end: tracks byte position, CRC and header/entry capture, classifies bytes.
// Depends on thdc_pkg; pushes result events into thdc_queue.
`default_nettype none

module thdc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic [0:0]       s_tuser,
    input  thdc_pkg::cfg_t   cfg,
    input  logic             q_ready,
    output logic             q_push,
    output thdc_pkg::evt_t   q_evt
);
    import thdc_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [31:0]        crc_reg, crc_next;
    logic               done_reg, done_next;
    logic               magic_reg, magic_next;
    logic [15:0]        version_reg, version_next;
    logic [7:0]         zoom_reg, zoom_next;
    logic [HDR_W-1:0]   hdr_reg, hdr_next;
    logic [31:0]        crcst_reg, crcst_next;
    logic [3:0]         left_reg, left_next;
    logic [4:0]         k_reg, k_next;
    logic [ENTRY_W-1:0] ent_reg, ent_next;

    logic               start;
    logic [7:0]         b;
    logic [POS_W-1:0]   pos;
    logic [31:0]        crc_in;
    logic [31:0]        crc_new;
    logic               mok;
    logic [7:0]         crc_byte_in;
    status_t            status;
    status_t            crc_status;

    assign s_tready = q_ready;
    assign start    = s_tuser[0];
    assign b        = s_tdata;
    assign pos      = start ? '0 : pos_reg;
    assign crc_in   = start ? '1 : crc_reg;
    assign mok      = start ? 1'b1 : magic_reg;

    assign crc_byte_in = (pos >= P_CRC_LO && pos < P_CRC_END) ? 8'd0 : b;
    assign crc_new     = crc32_byte(crc_in, crc_byte_in);
    assign crc_status  = (~crc_new == crcst_reg) ? ST_OK : ST_CRC_BAD;

    always_comb begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        done_next    = done_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        zoom_next    = zoom_reg;
        hdr_next     = hdr_reg;
        crcst_next   = crcst_reg;
        left_next    = left_reg;
        k_next       = k_reg;
        ent_next     = ent_reg;
        q_push       = 1'b0;
        q_evt        = '0;
        status       = ST_OK;

        if (s_tvalid && q_ready && (start || !done_reg)) begin
            pos_next   = pos + 9'd1;
            crc_next   = crc_new;
            done_next  = 1'b0;
            magic_next = mok;
            if (pos < P_BODY) begin
                priority if (pos < P_VERSION) begin
                    magic_next = mok && (b == MAGIC_TAG[pos[1:0]]);
                end else if (pos < P_ZOOM) begin
                    version_next = {b, version_reg[15:8]};
                end else if (pos == P_ZOOM) begin
                    zoom_next = b;
                end else if (pos < P_HDR_END) begin
                    hdr_next = {b, hdr_reg[HDR_W-1:8]};
                end else if (pos >= P_CRC_LO && pos < P_CRC_END) begin
                    crcst_next = {b, crcst_reg[31:8]};
                end else if (pos == P_COUNT) begin
                    priority if (!mok) begin
                        status = ST_BAD_MAGIC;
                    end else if (version_reg != cfg.expected_version) begin
                        status = ST_BAD_VERSION;
                    end else if (b > {4'b0, cfg.layer_limit}) begin
                        status = ST_TOO_MANY;
                    end else begin
                        status = ST_OK;
                    end
                    q_push             = 1'b1;
                    q_evt.first_kind   = KIND_HEADER;
                    q_evt.first_status = status;
                    q_evt.data         = {32'b0, hdr_reg, zoom_reg};
                    left_next          = b[3:0];
                    k_next             = '0;
                    if (status != ST_OK) begin
                        q_evt.has_verdict    = 1'b1;
                        q_evt.verdict_status = status;
                        done_next            = 1'b1;
                    end else if (b == 8'd0) begin
                        q_evt.has_verdict    = 1'b1;
                        q_evt.verdict_status = crc_status;
                        done_next            = 1'b1;
                    end
                end else begin
                    // epoch bytes: CRC only
                end
            end else begin
                ent_next = {b, ent_reg[ENTRY_W-1:8]};
                if (k_reg == K_LAST) begin
                    k_next             = '0;
                    left_next          = left_reg - 4'd1;
                    q_push             = 1'b1;
                    q_evt.first_kind   = KIND_ENTRY;
                    q_evt.first_status = ST_OK;
                    q_evt.data         = ent_next;
                    if (left_reg == 4'd1) begin
                        q_evt.has_verdict    = 1'b1;
                        q_evt.verdict_status = crc_status;
                        done_next            = 1'b1;
                    end
                end else begin
                    k_next = k_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            crc_reg   <= '1;
            done_reg  <= 1'b1;
            magic_reg <= 1'b1;
            left_reg  <= '0;
            k_reg     <= '0;
        end else begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            done_reg  <= done_next;
            magic_reg <= magic_next;
            left_reg  <= left_next;
            k_reg     <= k_next;
        end
        version_reg <= version_next;
        zoom_reg    <= zoom_next;
        hdr_reg     <= hdr_next;
        crcst_reg   <= crcst_next;
        ent_reg     <= ent_next;
    end

endmodule

`default_nettype wire

>>> sv/thdc_queue.sv
// Two-entry event queue between the front end and the result back end.
// Depends on thdc_pkg for the event and status types.
`default_nettype none

module thdc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  thdc_pkg::evt_t     evt_in,
    output logic               ready,
    input  logic               pop,
    output logic               valid,
    output thdc_pkg::evt_t     evt_out,
    output thdc_pkg::q_stat_t  stat
);
    import thdc_pkg::*;

    evt_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, wr_next;
    logic [Q_PTR_W-1:0] rd_reg, rd_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign stat.count = cnt_reg;
    assign stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign ready      = !stat.full;
    assign valid      = !stat.empty;
    assign evt_out    = slot_reg[rd_reg];
    assign do_push    = push && ready;
    assign do_pop     = pop && valid;

    always_comb begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (do_push) begin
            slot_reg[wr_reg] <= evt_in;
        end
    end

endmodule

`default_nettype wire

>>> sv/thdc_back.sv
// Back end: expands queued events into one or two result transactions.
// Depends on thdc_pkg; drives the registered result channel.
`default_nettype none

module thdc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  thdc_pkg::evt_t               q_evt,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [thdc_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser
);
    import thdc_pkg::*;

    back_state_t          state_reg, state_next;
    logic                 tvalid_reg, tvalid_next;
    logic [TDATA_W-1:0]   tdata_reg, tdata_next;
    kind_t                tuser_reg, tuser_next;
    logic                 load;

    function automatic logic [TDATA_W-1:0] pack_result(
        input kind_t kind, input status_t st, input logic [ENTRY_W-1:0] d);
        logic [TDATA_W-1:0] r;
        r = '0;
        unique case (kind)
            KIND_HEADER: r = {5'b0, {ENTRY_W{1'b0}}, d[HDR_W+7:0], st};
            KIND_ENTRY:  r = {5'b0, d, {HDR_W{1'b0}}, 8'b0, st};
            default:     r = {{(TDATA_W-3){1'b0}}, st};
        endcase
        return r;
    endfunction

    assign load     = !tvalid_reg || m_tready;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    always_comb begin
        state_next  = state_reg;
        tvalid_next = tvalid_reg;
        tdata_next  = tdata_reg;
        tuser_next  = tuser_reg;
        q_pop       = 1'b0;
        if (load) begin
            tvalid_next = q_valid;
            if (q_valid) begin
                unique case (state_reg)
                    BK_FIRST: begin
                        tuser_next = q_evt.first_kind;
                        tdata_next = pack_result(q_evt.first_kind, q_evt.first_status,
                                                 q_evt.data);
                        if (q_evt.has_verdict) begin
                            state_next = BK_SECOND;
                        end else begin
                            q_pop = 1'b1;
                        end
                    end
                    BK_SECOND: begin
                        tuser_next = KIND_VERDICT;
                        tdata_next = pack_result(KIND_VERDICT, q_evt.verdict_status,
                                                 q_evt.data);
                        q_pop      = 1'b1;
                        state_next = BK_FIRST;
                    end
                    default: state_next = BK_FIRST;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_FIRST;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tvalid_reg <= tvalid_next;
        end
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
    end

endmodule

`default_nettype wire

>>> sv/tile_header_directory_check.sv
// Top level of the tile header directory check: config registers, front, queue, back.
// Depends on thdc_pkg, thdc_front, thdc_queue, thdc_back and assert_macros.svh.
//
//   channel  | direction | handshake            | payload
//   s_       | in        | s_tvalid / s_tready  | s_tdata: data_byte; s_tuser: starts_tile
//   m_       | out       | m_tvalid / m_tready  | m_tdata: status .. index_location; m_tuser: kind
//   cfg_     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One byte per cycle while s_tready is high; a result passes through a queue slot and
// then the output register. A byte that closes a tile yields two results, its header
// or entry result and then the verdict. A two-entry event queue decouples byte intake
// from result output; s_tready drops only while it is full. Reset restarts position
// and CRC and idles the checker until a byte with starts_tile; cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"

module tile_header_directory_check (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic [0:0]   s_tuser,    // [0] starts_tile
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [311:0] m_tdata,    // [2:0] status, [10:3] zoom, [42:11] tile_x,
                                     // [74:43] tile_y, [106:75] anchor_x,
                                     // [138:107] anchor_y, [146:139] layer_id,
                                     // [178:147] entry_offset, [210:179] entry_length,
                                     // [242:211] entry_crc, [306:243] index_location
    output logic [1:0]   m_tuser,    // [1:0] result_kind
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import thdc_pkg::*;

    cfg_t    cfg_reg;
    logic    q_push;
    logic    q_ready;
    logic    q_pop;
    logic    q_valid;
    evt_t    evt_in;
    evt_t    evt_out;
    q_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_version <= 16'd3;
            cfg_reg.layer_limit      <= 4'd6;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_IDX_VERSION) begin
                cfg_reg.expected_version <= cfg_data;
            end else if (cfg_index == CFG_IDX_LAYER_LIMIT) begin
                cfg_reg.layer_limit <= cfg_data[3:0];
            end
        end
    end

    thdc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_evt    (evt_in)
    );

    thdc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .evt_in  (evt_in),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .evt_out (evt_out),
        .stat    (q_stat)
    );

    thdc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_evt    (evt_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `THDC_ASSERT(a_queue_bound, q_stat.count <= Q_CNT_W'(Q_DEPTH), "event queue overflow")
    `THDC_ASSERT_IMP(a_verdict_clean, m_tvalid && m_tuser == KIND_VERDICT, m_tdata[311:3] == '0, "verdict carries stray fields")
    `THDC_ASSERT_IMP(a_entry_ok, m_tvalid && m_tuser == KIND_ENTRY, m_tdata[2:0] == ST_OK, "entry carries a failure status")

endmodule

`default_nettype wire
